FILE: rtl/assert_macros.svh
// Assertion helpers; the asserting module provides clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/ths_pkg.sv
`timescale 1ns / 1ps
package ths_pkg;

	localparam int TIMER_SLOTS_DEF = 256;
	localparam int HEAP_DEPTH_DEF  = 512;
	localparam int MAX_FIRES_DEF   = 63;
	localparam int TIME_BITS_DEF   = 48;
	localparam int GEN_BITS_DEF    = 16;

	localparam int FUNC_W   = 3;
	localparam int NOW_W    = 48;
	localparam int DELAY_W  = 32;
	localparam int PERIOD_W = 32;
	localparam int HANDLE_W = 9;
	localparam int TAG_W    = 16;
	localparam int STATUS_W = 3;
	localparam int ACTIVE_W = 9;
	localparam int QDEPTH   = 2;

	typedef enum logic [FUNC_W-1:0] {
		OP_CREATE = 3'd0,
		OP_CANCEL = 3'd1,
		OP_PAUSE  = 3'd2,
		OP_RESUME = 3'd3,
		OP_UPDATE = 3'd4,
		OP_QUERY  = 3'd5,
		OP_BAD    = 3'd6
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		RS_OK         = 3'd0,
		RS_REJECTED   = 3'd1,
		RS_POOL_FULL  = 3'd2,
		RS_QUEUE_FULL = 3'd3,
		RS_FIRED      = 3'd4,
		RS_FIRED_DROP = 3'd5,
		RS_DONE       = 3'd6
	} res_status_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN_W,
		ST_SCAN_C,
		ST_LK_W,
		ST_LK_C,
		ST_PUSH_UP,
		ST_PUSH_W,
		ST_PUSH_CMP,
		ST_UPD_CHK,
		ST_UPD_W,
		ST_UPD_TOP,
		ST_POP_W1,
		ST_POP_LAST,
		ST_POP_DOWN,
		ST_POP_WL,
		ST_POP_L,
		ST_POP_WR,
		ST_POP_R,
		ST_SLT_W,
		ST_SLT_C,
		ST_EMIT
	} state_t;

	typedef struct packed {
		op_t  op;
		logic handle_ok;
	} cmd_ctl_t;

endpackage

FILE: rtl/ths_if.sv
`timescale 1ns / 1ps
interface cmd_if;
	import ths_pkg::*;
	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [NOW_W-1:0]    now;
	logic [DELAY_W-1:0]  delay;
	logic [PERIOD_W-1:0] repeat_interval;
	logic [HANDLE_W-1:0] handle;
	logic [TAG_W-1:0]    callback_tag;

	modport source (output valid, func, now, delay, repeat_interval, handle, callback_tag,
		input ready);
	modport sink (input valid, func, now, delay, repeat_interval, handle, callback_tag,
		output ready);
endinterface

interface res_if;
	import ths_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [HANDLE_W-1:0] timer_handle;
	logic [TAG_W-1:0]    fired_tag;
	logic                is_paused;
	logic [ACTIVE_W-1:0] active_timers;
	logic                last;

	modport source (output valid, status, timer_handle, fired_tag, is_paused, active_timers,
		last, input ready);
	modport sink (input valid, status, timer_handle, fired_tag, is_paused, active_timers,
		last, output ready);
endinterface

FILE: rtl/timer_heap_scheduler_unit.sv
`timescale 1ns / 1ps
// Timer pool with a min-heap of due times.
// cmd channel: one command item (create, cancel, pause, resume, update,
// query) per handshake; valid/ready, taken when both are high.
// res channel: result items, each with last set on the final result of its
// command. Update gives one item per fired timer, then one done item.
// A two-entry command queue sits in front of a sequencer that owns the slot
// and heap memories, so up to two commands are taken while one runs.
// A create scans for the lowest free slot and then sifts up the heap;
// cancel, pause and query look up the slot of their handle; each pop
// sifts down the heap. The sequencer runs one command at a time,
// bounded by its memory port.
// Reset: the slot status memory is cleared slot by slot; cmd ready stays
// low until that is done.
// A stalled res receiver holds the output register; the sequencer waits on
// the next result and the command queue keeps filling until full.
module timer_heap_scheduler_unit #(
	parameter int TIMER_SLOTS = ths_pkg::TIMER_SLOTS_DEF,
	parameter int HEAP_DEPTH  = ths_pkg::HEAP_DEPTH_DEF,
	parameter int MAX_FIRES   = ths_pkg::MAX_FIRES_DEF,
	parameter int TIME_BITS   = ths_pkg::TIME_BITS_DEF,
	parameter int GEN_BITS    = ths_pkg::GEN_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	cmd_if.sink   cmd,
	res_if.source res
);
	import ths_pkg::*;

	localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

	logic                 q_valid, q_pop, clearing;
	cmd_ctl_t             q_ctl;
	logic [TIME_BITS-1:0] q_now;
	logic [DELAY_W-1:0]   q_delay;
	logic [PERIOD_W-1:0]  q_period;
	logic [SLOT_W-1:0]    q_slot;
	logic [TAG_W-1:0]     q_tag;

	ths_front #(
		.TIMER_SLOTS (TIMER_SLOTS),
		.TIME_BITS   (TIME_BITS),
		.SLOT_W      (SLOT_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.clearing (clearing),
		.pop      (q_pop),
		.q_valid  (q_valid),
		.q_ctl    (q_ctl),
		.q_now    (q_now),
		.q_delay  (q_delay),
		.q_period (q_period),
		.q_slot   (q_slot),
		.q_tag    (q_tag)
	);

	ths_back #(
		.TIMER_SLOTS (TIMER_SLOTS),
		.HEAP_DEPTH  (HEAP_DEPTH),
		.MAX_FIRES   (MAX_FIRES),
		.TIME_BITS   (TIME_BITS),
		.GEN_BITS    (GEN_BITS),
		.SLOT_W      (SLOT_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_ctl    (q_ctl),
		.q_now    (q_now),
		.q_delay  (q_delay),
		.q_period (q_period),
		.q_slot   (q_slot),
		.q_tag    (q_tag),
		.q_pop    (q_pop),
		.clearing (clearing),
		.res      (res)
	);

endmodule

FILE: rtl/ths_front.sv
`timescale 1ns / 1ps
module ths_front #(
	parameter int TIMER_SLOTS = ths_pkg::TIMER_SLOTS_DEF,
	parameter int TIME_BITS   = ths_pkg::TIME_BITS_DEF,
	parameter int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	cmd_if.sink                       cmd,
	input  logic                      clearing,
	input  logic                      pop,
	output logic                      q_valid,
	output ths_pkg::cmd_ctl_t         q_ctl,
	output logic [TIME_BITS-1:0]      q_now,
	output logic [ths_pkg::DELAY_W-1:0]  q_delay,
	output logic [ths_pkg::PERIOD_W-1:0] q_period,
	output logic [SLOT_W-1:0]         q_slot,
	output logic [ths_pkg::TAG_W-1:0] q_tag
);
	import ths_pkg::*;

	cmd_ctl_t              ctl;
	logic [63:0]           now64;
	logic [31:0]           hm1;
	logic                  push;
	logic                  wp_q, rp_q;
	logic [1:0]            cnt_q;
	cmd_ctl_t              ctl_q    [QDEPTH];
	logic [TIME_BITS-1:0]  now_q    [QDEPTH];
	logic [DELAY_W-1:0]    delay_q  [QDEPTH];
	logic [PERIOD_W-1:0]   period_q [QDEPTH];
	logic [SLOT_W-1:0]     slot_q   [QDEPTH];
	logic [TAG_W-1:0]      tag_q    [QDEPTH];

	// classify the command
	always_comb begin
		case (cmd.func)
			OP_CREATE: ctl.op = OP_CREATE;
			OP_CANCEL: ctl.op = OP_CANCEL;
			OP_PAUSE:  ctl.op = OP_PAUSE;
			OP_RESUME: ctl.op = OP_RESUME;
			OP_UPDATE: ctl.op = OP_UPDATE;
			OP_QUERY:  ctl.op = OP_QUERY;
			default:   ctl.op = OP_BAD;
		endcase
		ctl.handle_ok = (cmd.handle != '0) && (32'(cmd.handle) <= 32'(TIMER_SLOTS));
	end

	assign now64     = 64'(cmd.now);
	assign hm1       = 32'(cmd.handle) - 32'd1;
	assign cmd.ready = !clearing && (cnt_q != 2'(QDEPTH));
	assign push      = cmd.valid && cmd.ready;
	assign q_valid   = (cnt_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			ctl_q[wp_q]    <= ctl;
			now_q[wp_q]    <= now64[TIME_BITS-1:0];
			delay_q[wp_q]  <= cmd.delay;
			period_q[wp_q] <= cmd.repeat_interval;
			slot_q[wp_q]   <= hm1[SLOT_W-1:0];
			tag_q[wp_q]    <= cmd.callback_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign q_ctl    = ctl_q[rp_q];
	assign q_now    = now_q[rp_q];
	assign q_delay  = delay_q[rp_q];
	assign q_period = period_q[rp_q];
	assign q_slot   = slot_q[rp_q];
	assign q_tag    = tag_q[rp_q];

endmodule

FILE: rtl/ths_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ths_back #(
	parameter int TIMER_SLOTS = ths_pkg::TIMER_SLOTS_DEF,
	parameter int HEAP_DEPTH  = ths_pkg::HEAP_DEPTH_DEF,
	parameter int MAX_FIRES   = ths_pkg::MAX_FIRES_DEF,
	parameter int TIME_BITS   = ths_pkg::TIME_BITS_DEF,
	parameter int GEN_BITS    = ths_pkg::GEN_BITS_DEF,
	parameter int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_valid,
	input  ths_pkg::cmd_ctl_t         q_ctl,
	input  logic [TIME_BITS-1:0]      q_now,
	input  logic [ths_pkg::DELAY_W-1:0]  q_delay,
	input  logic [ths_pkg::PERIOD_W-1:0] q_period,
	input  logic [SLOT_W-1:0]         q_slot,
	input  logic [ths_pkg::TAG_W-1:0] q_tag,
	output logic                      q_pop,
	output logic                      clearing,
	res_if.source                     res
);
	import ths_pkg::*;

	localparam int HA_W   = $clog2(HEAP_DEPTH);
	localparam int CNT_W  = $clog2(HEAP_DEPTH + 1);
	localparam int ACT_W  = $clog2(TIMER_SLOTS + 1);
	localparam int FIRE_W = $clog2(MAX_FIRES + 1);
	localparam int REF_W  = SLOT_W + GEN_BITS;
	localparam int HE_W   = TIME_BITS + REF_W;
	localparam int ST_W   = GEN_BITS + 2;
	localparam int PT_W   = PERIOD_W + TAG_W;
	localparam int SUM_W  = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;
	localparam logic [TIME_BITS-1:0] TMAX = '1;

	// memories
	logic [ST_W-1:0]      st_mem [TIMER_SLOTS];
	logic [TIME_BITS-1:0] tm_mem [TIMER_SLOTS];
	logic [PT_W-1:0]      pt_mem [TIMER_SLOTS];
	logic [HE_W-1:0]      h_mem  [HEAP_DEPTH];
	logic [ST_W-1:0]      st_rd_q;
	logic [TIME_BITS-1:0] tm_rd_q;
	logic [PT_W-1:0]      pt_rd_q;
	logic [HE_W-1:0]      h_rd_q;

	logic                 st_we, tm_we, pt_we, h_we;
	logic [ST_W-1:0]      st_wd;
	logic [TIME_BITS-1:0] tm_wd;
	logic [PT_W-1:0]      pt_wd;
	logic [HE_W-1:0]      h_wd;

	state_t               state_q, state_d;
	logic [SLOT_W-1:0]    addr_q;
	logic [HA_W-1:0]      h_addr_q, hole_q;
	logic [CNT_W-1:0]     count_q;
	logic [ACT_W-1:0]     act_q;
	logic [FIRE_W-1:0]    n_q;
	logic [HE_W-1:0]      x_q, lt_q, push_q;
	logic [REF_W-1:0]     top_ref_q;
	op_t                  op_q;
	logic [TIME_BITS-1:0] now_q;
	logic [DELAY_W-1:0]   delay_q;
	logic [PERIOD_W-1:0]  period_q;
	logic [TAG_W-1:0]     tag_q;
	res_status_t          rs_q;
	logic [HANDLE_W-1:0]  rh_q;
	logic [TAG_W-1:0]     rt_q;
	logic                 rp_q, rl_q;
	logic                 out_valid_q;

	logic                 st_active, st_paused, live, heap_full, out_free;
	logic [GEN_BITS-1:0]  st_gen, top_gen;
	logic [SLOT_W-1:0]    top_slot, hr_slot;
	logic [TIME_BITS-1:0] hr_time, x_time, left_time, best_time, push_time, due, rem;
	logic [HE_W-1:0]      left_e, child_e, x_or_child;
	logic [CNT_W:0]       l_idx, r_idx;
	logic                 l_in, r_in, left_wins, right_wins, go_child, push_lt;
	logic [HA_W-1:0]      child_idx, parent_idx;
	logic [SUM_W-1:0]     add_b, sum;
	logic [PERIOD_W-1:0]  period_rd;
	logic [HANDLE_W-1:0]  cur_handle;
	logic [ST_W-1:0]      release_wd;

	always_ff @(posedge clk) begin
		if (st_we)
			st_mem[addr_q] <= st_wd;
		if (tm_we)
			tm_mem[addr_q] <= tm_wd;
		if (pt_we)
			pt_mem[addr_q] <= pt_wd;
		if (h_we)
			h_mem[hole_q] <= h_wd;
		st_rd_q <= st_mem[addr_q];
		tm_rd_q <= tm_mem[addr_q];
		pt_rd_q <= pt_mem[addr_q];
		h_rd_q  <= h_mem[h_addr_q];
	end

	assign st_active  = st_rd_q[ST_W-1];
	assign st_paused  = st_rd_q[ST_W-2];
	assign st_gen     = st_rd_q[GEN_BITS-1:0];
	assign top_slot   = top_ref_q[REF_W-1:GEN_BITS];
	assign top_gen    = top_ref_q[GEN_BITS-1:0];
	assign hr_time    = h_rd_q[HE_W-1 -: TIME_BITS];
	assign hr_slot    = h_rd_q[REF_W-1:GEN_BITS];
	assign x_time     = x_q[HE_W-1 -: TIME_BITS];
	assign push_time  = push_q[HE_W-1 -: TIME_BITS];
	assign live       = st_active && !st_paused && (st_gen == top_gen);
	assign heap_full  = (count_q >= CNT_W'(HEAP_DEPTH));
	assign out_free   = !out_valid_q || res.ready;
	assign period_rd  = pt_rd_q[PT_W-1:TAG_W];
	assign cur_handle = HANDLE_W'(32'(addr_q) + 32'd1);
	assign release_wd = {1'b0, 1'b0, st_gen + 1'b1};
	assign clearing   = (state_q == ST_CLEAR);

	// heap index arithmetic
	assign l_idx      = (CNT_W + 1)'({hole_q, 1'b1});
	assign r_idx      = l_idx + 1'b1;
	assign l_in       = l_idx < (CNT_W + 1)'(count_q);
	assign r_in       = r_idx < (CNT_W + 1)'(count_q);
	assign parent_idx = (hole_q - 1'b1) >> 1;
	assign push_lt    = push_time < hr_time;

	// sift-down child selection
	assign left_e     = (state_q == ST_POP_R) ? lt_q : h_rd_q;
	assign left_time  = left_e[HE_W-1 -: TIME_BITS];
	assign left_wins  = left_time < x_time;
	assign best_time  = left_wins ? left_time : x_time;
	assign right_wins = (state_q == ST_POP_R) && (hr_time < best_time);
	assign go_child   = left_wins || right_wins;
	assign child_e    = right_wins ? h_rd_q : left_e;
	assign child_idx  = right_wins ? r_idx[HA_W-1:0] : l_idx[HA_W-1:0];
	assign x_or_child = go_child ? child_e : x_q;

	// saturating due time
	always_comb begin
		case (state_q)
			ST_LK_C: add_b = SUM_W'(tm_rd_q);
			ST_SLT_C: add_b = SUM_W'(period_rd);
			default: add_b = SUM_W'(delay_q);
		endcase
		sum = SUM_W'(now_q) + add_b;
		due = (sum > SUM_W'(TMAX)) ? TMAX : sum[TIME_BITS-1:0];
		rem = (tm_rd_q > now_q) ? (tm_rd_q - now_q) : '0;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:
				if (addr_q == SLOT_W'(TIMER_SLOTS - 1))
					state_d = ST_IDLE;
			ST_IDLE:
				if (q_valid) begin
					case (q_ctl.op)
						OP_CREATE: state_d = ST_SCAN_W;
						OP_UPDATE: state_d = ST_UPD_CHK;
						OP_CANCEL, OP_PAUSE, OP_RESUME, OP_QUERY:
							state_d = q_ctl.handle_ok ? ST_LK_W : ST_EMIT;
						default: state_d = ST_EMIT;
					endcase
				end
			ST_SCAN_W: state_d = ST_SCAN_C;
			ST_SCAN_C:
				if (!st_active)
					state_d = heap_full ? ST_EMIT : ST_PUSH_UP;
				else if (addr_q == SLOT_W'(TIMER_SLOTS - 1))
					state_d = ST_EMIT;
				else
					state_d = ST_SCAN_W;
			ST_LK_W: state_d = ST_LK_C;
			ST_LK_C:
				if (op_q == OP_RESUME && st_active && st_paused && !heap_full)
					state_d = ST_PUSH_UP;
				else
					state_d = ST_EMIT;
			ST_PUSH_UP: state_d = (hole_q == '0) ? ST_EMIT : ST_PUSH_W;
			ST_PUSH_W: state_d = ST_PUSH_CMP;
			ST_PUSH_CMP: state_d = push_lt ? ST_PUSH_UP : ST_EMIT;
			ST_UPD_CHK:
				if (count_q == '0 || n_q == FIRE_W'(MAX_FIRES))
					state_d = ST_EMIT;
				else
					state_d = ST_UPD_W;
			ST_UPD_W: state_d = ST_UPD_TOP;
			ST_UPD_TOP:
				if (hr_time > now_q)
					state_d = ST_EMIT;
				else if (count_q == CNT_W'(1))
					state_d = ST_SLT_W;
				else
					state_d = ST_POP_W1;
			ST_POP_W1: state_d = ST_POP_LAST;
			ST_POP_LAST: state_d = ST_POP_DOWN;
			ST_POP_DOWN: state_d = l_in ? ST_POP_WL : ST_SLT_W;
			ST_POP_WL: state_d = ST_POP_L;
			ST_POP_L:
				if (r_in)
					state_d = ST_POP_WR;
				else
					state_d = go_child ? ST_POP_DOWN : ST_SLT_W;
			ST_POP_WR: state_d = ST_POP_R;
			ST_POP_R: state_d = go_child ? ST_POP_DOWN : ST_SLT_W;
			ST_SLT_W: state_d = ST_SLT_C;
			ST_SLT_C:
				if (!live)
					state_d = ST_UPD_CHK;
				else if (period_rd != '0 && !heap_full)
					state_d = ST_PUSH_UP;
				else
					state_d = ST_EMIT;
			ST_EMIT:
				if (out_free)
					state_d = rl_q ? ST_IDLE : ST_UPD_CHK;
			default: state_d = ST_CLEAR;
		endcase
	end

	// memory writes and queue pop
	always_comb begin
		st_we = 1'b0;
		st_wd = '0;
		tm_we = 1'b0;
		tm_wd = due;
		pt_we = 1'b0;
		pt_wd = {period_q, tag_q};
		h_we  = 1'b0;
		h_wd  = push_q;
		q_pop = 1'b0;
		case (state_q)
			ST_CLEAR: st_we = 1'b1;
			ST_IDLE: q_pop = q_valid;
			ST_SCAN_C:
				if (!st_active && !heap_full) begin
					st_we = 1'b1;
					st_wd = {1'b1, 1'b0, st_gen};
					tm_we = 1'b1;
					pt_we = 1'b1;
				end
			ST_LK_C:
				case (op_q)
					OP_CANCEL:
						if (st_active) begin
							st_we = 1'b1;
							st_wd = release_wd;
						end
					OP_PAUSE:
						if (st_active && !st_paused) begin
							tm_we = 1'b1;
							tm_wd = rem;
							st_we = 1'b1;
							st_wd = {1'b1, 1'b1, st_gen + 1'b1};
						end
					OP_RESUME:
						if (st_active && st_paused && !heap_full) begin
							tm_we = 1'b1;
							st_we = 1'b1;
							st_wd = {1'b1, 1'b0, st_gen};
						end
					default: st_we = 1'b0;
				endcase
			ST_PUSH_UP: h_we = (hole_q == '0);
			ST_PUSH_CMP: begin
				h_we = 1'b1;
				h_wd = push_lt ? h_rd_q : push_q;
			end
			ST_POP_DOWN: begin
				h_we = !l_in;
				h_wd = x_q;
			end
			ST_POP_L: begin
				h_we = !r_in;
				h_wd = x_or_child;
			end
			ST_POP_R: begin
				h_we = 1'b1;
				h_wd = x_or_child;
			end
			ST_SLT_C:
				if (live) begin
					tm_we = (period_rd != '0);
					st_we = (period_rd == '0) || heap_full;
					st_wd = release_wd;
				end
			default: h_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_d;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q  <= '0;
			count_q <= '0;
			act_q   <= '0;
			n_q     <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: addr_q <= addr_q + 1'b1;
				ST_IDLE:
					if (q_valid) begin
						n_q <= '0;
						if (q_ctl.op == OP_CREATE)
							addr_q <= '0;
						else
							addr_q <= q_slot;
					end
				ST_SCAN_C:
					if (!st_active) begin
						if (!heap_full) begin
							act_q   <= act_q + 1'b1;
							count_q <= count_q + 1'b1;
						end
					end else if (addr_q != SLOT_W'(TIMER_SLOTS - 1)) begin
						addr_q <= addr_q + 1'b1;
					end
				ST_LK_C:
					if (op_q == OP_CANCEL && st_active && act_q != '0)
						act_q <= act_q - 1'b1;
					else if (op_q == OP_RESUME && st_active && st_paused && !heap_full)
						count_q <= count_q + 1'b1;
				ST_UPD_TOP:
					if (hr_time <= now_q) begin
						count_q <= count_q - 1'b1;
						addr_q  <= hr_slot;
					end
				ST_SLT_C:
					if (live) begin
						n_q <= n_q + 1'b1;
						if (period_rd != '0 && !heap_full)
							count_q <= count_q + 1'b1;
						else if (act_q != '0)
							act_q <= act_q - 1'b1;
					end
				default: addr_q <= addr_q;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE:
				if (q_valid) begin
					op_q     <= q_ctl.op;
					now_q    <= q_now;
					delay_q  <= q_delay;
					period_q <= q_period;
					tag_q    <= q_tag;
					rs_q     <= (q_ctl.op == OP_QUERY) ? RS_OK : RS_REJECTED;
					rh_q     <= '0;
					rt_q     <= '0;
					rp_q     <= 1'b0;
					rl_q     <= 1'b1;
				end
			ST_SCAN_C:
				if (!st_active) begin
					if (heap_full) begin
						rs_q <= RS_QUEUE_FULL;
					end else begin
						rs_q   <= RS_OK;
						rh_q   <= cur_handle;
						push_q <= {due, addr_q, st_gen};
						hole_q <= count_q[HA_W-1:0];
					end
				end else if (addr_q == SLOT_W'(TIMER_SLOTS - 1)) begin
					rs_q <= RS_POOL_FULL;
				end
			ST_LK_C:
				case (op_q)
					OP_QUERY: rp_q <= st_active && st_paused;
					OP_CANCEL:
						if (st_active)
							rs_q <= RS_OK;
					OP_PAUSE:
						if (st_active && !st_paused)
							rs_q <= RS_OK;
					OP_RESUME:
						if (st_active && st_paused) begin
							rs_q   <= heap_full ? RS_QUEUE_FULL : RS_OK;
							push_q <= {due, addr_q, st_gen};
							hole_q <= count_q[HA_W-1:0];
						end
					default: rs_q <= RS_REJECTED;
				endcase
			ST_PUSH_UP: h_addr_q <= parent_idx;
			ST_PUSH_CMP:
				if (push_lt)
					hole_q <= h_addr_q;
			ST_UPD_CHK: begin
				h_addr_q <= '0;
				rs_q     <= RS_DONE;
				rh_q     <= '0;
				rt_q     <= '0;
				rl_q     <= 1'b1;
			end
			ST_UPD_TOP: begin
				top_ref_q <= h_rd_q[REF_W-1:0];
				h_addr_q  <= HA_W'(count_q - 1'b1);
			end
			ST_POP_LAST: begin
				x_q    <= h_rd_q;
				hole_q <= '0;
			end
			ST_POP_DOWN: h_addr_q <= l_idx[HA_W-1:0];
			ST_POP_L: begin
				lt_q <= h_rd_q;
				if (r_in)
					h_addr_q <= r_idx[HA_W-1:0];
				else if (go_child)
					hole_q <= child_idx;
			end
			ST_POP_R:
				if (go_child)
					hole_q <= child_idx;
			ST_SLT_C:
				if (live) begin
					rh_q <= cur_handle;
					rt_q <= pt_rd_q[TAG_W-1:0];
					rl_q <= 1'b0;
					if (period_rd != '0 && !heap_full) begin
						rs_q   <= RS_FIRED;
						push_q <= {due, addr_q, st_gen};
						hole_q <= count_q[HA_W-1:0];
					end else begin
						rs_q <= (period_rd != '0) ? RS_FIRED_DROP : RS_FIRED;
					end
				end
			default: rl_q <= rl_q;
		endcase
	end

	// the address of the slot being fired is the popped ref
	always_comb begin
		top_slot_chk = (top_slot == addr_q);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == ST_EMIT && out_free)
			out_valid_q <= 1'b1;
		else if (res.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			res.status        <= rs_q;
			res.timer_handle  <= rh_q;
			res.fired_tag     <= rt_q;
			res.is_paused     <= rp_q;
			res.active_timers <= ACTIVE_W'(act_q);
			res.last          <= rl_q;
		end
	end

	assign res.valid = out_valid_q;

	logic top_slot_chk;

	`ASSERT_IMPL(a_heap_bound, 1'b1, count_q <= CNT_W'(HEAP_DEPTH))
	`ASSERT_IMPL(a_act_bound, 1'b1, 32'(act_q) <= 32'(TIMER_SLOTS))
	`ASSERT_IMPL(a_no_pop_clear, state_q == ST_CLEAR, !q_pop)
	`ASSERT_IMPL(a_fire_slot, state_q == ST_SLT_C, top_slot_chk)

endmodule
